// ===== rtl/core/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int UNIT_BYTES  = 16;
  localparam int MAX_FREE    = 64;

  localparam int AW = $clog2(ARENA_UNITS);      // unit offset width
  localparam int IW = $clog2(MAX_FREE);         // free list index width
  localparam int CW = $clog2(MAX_FREE + 1);     // free count width
  localparam int UB = $clog2(UNIT_BYTES);       // byte to unit shift
  localparam int SW = 24 - UB + 1;              // size in units width

  // one free list entry: header offset and data length
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
  } entry_t;

  // chain operations
  localparam logic [2:0] CH_NONE   = 3'd0;
  localparam logic [2:0] CH_ROT    = 3'd1;
  localparam logic [2:0] CH_REMOVE = 3'd2;
  localparam logic [2:0] CH_INSERT = 3'd3;
  localparam logic [2:0] CH_WRITE  = 3'd4;
  localparam logic [2:0] CH_LOAD0  = 3'd5;

  // per cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_NEXT = 2'd1;
  localparam logic [1:0] CELL_PREV = 2'd2;
  localparam logic [1:0] CELL_LOAD = 2'd3;

  typedef struct packed {
    logic [2:0]    op;
    logic [IW-1:0] idx;
    entry_t        wdata;
  } chain_ctrl_t;

  // commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_RESIZE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

// ===== rtl/core/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell
// One free list entry; takes its neighbour's entry or a new one.
// ----------------------------------------------------------------------------
module ffa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffa_pkg::entry_t rst_val_i,
  input  logic [1:0]      op_i,
  input  ffa_pkg::entry_t next_i,
  input  ffa_pkg::entry_t prev_i,
  input  ffa_pkg::entry_t load_i,
  output ffa_pkg::entry_t q_o
);

  ffa_pkg::entry_t ent_q, ent_d;

  // neighbour select
  always_comb begin
    case (op_i)
      ffa_pkg::CELL_NEXT: ent_d = next_i;
      ffa_pkg::CELL_PREV: ent_d = prev_i;
      ffa_pkg::CELL_LOAD: ent_d = load_i;
      default:            ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= rst_val_i;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign q_o = ent_q;

endmodule

// ===== rtl/core/ffa_chain.sv =====
// ----------------------------------------------------------------------------
// ffa_chain
// Ordered free list as a ring of cells: rotate, remove, insert, write, load entry zero.
// ----------------------------------------------------------------------------
module ffa_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffa_pkg::chain_ctrl_t ctrl_i,
  output ffa_pkg::entry_t      head_o
);

  localparam int N = ffa_pkg::MAX_FREE;

  ffa_pkg::entry_t cell_q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [1:0]      op;
    ffa_pkg::entry_t rst_val;
    logic [ffa_pkg::IW-1:0] my_idx;

    assign my_idx = ffa_pkg::IW'(i);

    // reset: entry zero spans the whole arena
    always_comb begin
      rst_val = '0;
      if (i == 0) begin
        rst_val.len = ffa_pkg::AW'(ffa_pkg::ARENA_UNITS - 1);
      end
    end

    // per cell decode
    always_comb begin
      case (ctrl_i.op)
        ffa_pkg::CH_ROT:    op = ffa_pkg::CELL_NEXT;
        ffa_pkg::CH_REMOVE: op = (my_idx >= ctrl_i.idx) ? ffa_pkg::CELL_NEXT
                                                         : ffa_pkg::CELL_HOLD;
        ffa_pkg::CH_INSERT: op = (i == 0) ? ffa_pkg::CELL_LOAD : ffa_pkg::CELL_PREV;
        ffa_pkg::CH_WRITE:  op = (my_idx == ctrl_i.idx) ? ffa_pkg::CELL_LOAD
                                                         : ffa_pkg::CELL_HOLD;
        ffa_pkg::CH_LOAD0:  op = (i == 0) ? ffa_pkg::CELL_LOAD : ffa_pkg::CELL_HOLD;
        default:            op = ffa_pkg::CELL_HOLD;
      endcase
    end

    ffa_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rst_val_i (rst_val),
      .op_i      (op),
      .next_i    (cell_q[(i + 1) % N]),
      .prev_i    (cell_q[(i + N - 1) % N]),
      .load_i    (ctrl_i.wdata),
      .q_o       (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator: free list in a ring of cells, block lengths in a RAM.
// ----------------------------------------------------------------------------
// Allocate scans the free list, then applies the fit; release reads the
//   block length, scans and applies, with a removal step more when both
//   neighbours merge; resize may allocate then release; an unused command
//   goes straight to the result. Each free list pass is MAX_FREE rotations
//   of the ring. One transaction at a time, taken once the last is registered.
// Reset: one free block over 4096 units, free count one; block length RAM
//   holds no defined contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [23:0] request_bytes_i,
  input  logic        has_pointer_i,
  input  logic [11:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        has_result_o,
  output logic [11:0] result_address_o,
  output logic        moved_o,
  output logic [11:0] copy_units_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = ffa_pkg::AW;
  localparam int IW = ffa_pkg::IW;
  localparam int CW = ffa_pkg::CW;
  localparam int SW = ffa_pkg::SW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK_RD  = 4'd1;
  localparam logic [3:0] S_CHK     = 4'd2;
  localparam logic [3:0] S_A_SCAN  = 4'd3;
  localparam logic [3:0] S_A_APPLY = 4'd4;
  localparam logic [3:0] S_R_RD    = 4'd5;
  localparam logic [3:0] S_R_LAT   = 4'd6;
  localparam logic [3:0] S_R_SCAN  = 4'd7;
  localparam logic [3:0] S_R_APPLY = 4'd8;
  localparam logic [3:0] S_R_DEL   = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_SPLIT = 2'd1;
  localparam logic [1:0] K_WHOLE = 2'd2;
  localparam logic [1:0] K_FAIL  = 2'd3;

  logic [3:0]    state_q, state_d;
  logic [AW:0]   arena_q, arena_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] step_q, step_d;

  // transaction fields
  logic [1:0]    cmd_q;
  logic [23:0]   bytes_q;
  logic          ptr_q;
  logic [AW-1:0] addr_q;
  logic [SW-1:0] size_q, size_d;
  logic          move_q, move_d, shrink_q, shrink_d;
  logic [AW-1:0] rhdr_q, rhdr_d, alen_q, alen_d;

  // alloc scan record
  logic [1:0]    akind_q, akind_d;
  logic [IW-1:0] aidx_q, aidx_d;
  logic [AW-1:0] astart_q, astart_d, alen2_q, alen2_d, ahdr_q, ahdr_d;

  // release scan record
  logic          lf_q, lf_d, rf_q, rf_d;
  logic [IW-1:0] lidx_q, lidx_d, ridx_q, ridx_d;
  logic [AW-1:0] llen_q, llen_d, rlen_q, rlen_d;

  // result
  logic [1:0]    st_q, st_d;
  logic          hr_q, hr_d, mv_q, mv_d;
  logic [AW-1:0] res_q, res_d, cp_q, cp_d;

  logic          ov_q, ov_d;
  logic [1:0]    ost_q;
  logic          ohr_q, omv_q;
  logic [AW-1:0] ores_q, ocp_q;
  logic          oload;

  // block length RAM
  logic [AW-1:0] mem [ffa_pkg::ARENA_UNITS];
  logic [AW-1:0] rd_addr, rd_q, wr_addr, wr_data;
  logic          wr_en;

  ffa_pkg::chain_ctrl_t ctrl;
  ffa_pkg::entry_t      head;

  ffa_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // configuration port
  logic          cfg_we;
  logic [12:0]   cfg_v;
  logic [AW:0]   cfg_sat;

  assign pready = 1'b1;
  assign prdata = {{(32 - AW - 1){1'b0}}, arena_q};
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign cfg_v  = pwdata[12:0];

  always_comb begin
    if (cfg_v < 13'd2) begin
      cfg_sat = (AW + 1)'(2);
    end else if (cfg_v > 13'(ffa_pkg::ARENA_UNITS)) begin
      cfg_sat = (AW + 1)'(ffa_pkg::ARENA_UNITS);
    end else begin
      cfg_sat = (AW + 1)'(cfg_v);
    end
  end

  // scan helpers
  logic          live;
  logic [SW-1:0] hlen_w;
  logic [SW-1:0] asz;
  logic [AW-1:0] newlen;
  logic [AW:0]   shdr, lend, rbeg;
  logic [24:0]   bsum;
  logic [SW-1:0] units;
  logic [AW:0]   chk_sum;
  logic [AW-1:0] old_m_size;

  assign live    = ({1'b0, step_q} < count_q);
  assign hlen_w  = SW'(head.len);
  // allocation size: allocate, or resize without pointer, rounds up to at least one unit
  assign asz     = (cmd_q == ffa_pkg::CMD_ALLOC ||
                    (cmd_q == ffa_pkg::CMD_RESIZE && !ptr_q)) ?
                   ((units == '0) ? SW'(1) : units) : size_q;
  assign newlen  = head.len - asz[AW-1:0] - AW'(1);
  assign shdr    = {1'b0, head.start} + (AW + 1)'(1) + {1'b0, newlen};
  assign lend    = {1'b0, head.start} + (AW + 1)'(1) + {1'b0, head.len};
  assign rbeg    = {1'b0, rhdr_q} + (AW + 1)'(1) + {1'b0, alen_q};
  assign bsum    = {1'b0, bytes_q} + 25'(ffa_pkg::UNIT_BYTES - 1);
  assign units   = bsum[24:ffa_pkg::UB];
  assign chk_sum = {1'b0, addr_q} + {1'b0, rd_q};
  assign old_m_size = rd_q - size_q[AW-1:0];

  assign in_stall_o = (state_q != S_IDLE) || cfg_we;
  assign oload      = (state_q == S_FIN) && (!ov_q || !out_stall_i);

  // control sequencer
  always_comb begin
    state_d  = state_q;
    arena_d  = arena_q;
    count_d  = count_q;
    step_d   = step_q;
    size_d   = size_q;
    move_d   = move_q;
    shrink_d = shrink_q;
    rhdr_d   = rhdr_q;
    alen_d   = alen_q;
    akind_d  = akind_q;
    aidx_d   = aidx_q;
    astart_d = astart_q;
    alen2_d  = alen2_q;
    ahdr_d   = ahdr_q;
    lf_d     = lf_q;
    rf_d     = rf_q;
    lidx_d   = lidx_q;
    ridx_d   = ridx_q;
    llen_d   = llen_q;
    rlen_d   = rlen_q;
    st_d     = st_q;
    hr_d     = hr_q;
    mv_d     = mv_q;
    res_d    = res_q;
    cp_d     = cp_q;
    ctrl     = '0;
    rd_addr  = addr_q - AW'(1);
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;

    case (state_q)
      S_IDLE: begin
        if (cfg_we) begin
          arena_d          = cfg_sat;
          count_d          = CW'(1);
          ctrl.op          = ffa_pkg::CH_LOAD0;
          ctrl.wdata.start = '0;
          ctrl.wdata.len   = AW'(cfg_sat - (AW + 1)'(1));
        end else if (in_valid_i) begin
          st_d     = ffa_pkg::ST_DONE;
          hr_d     = 1'b0;
          mv_d     = 1'b0;
          res_d    = '0;
          cp_d     = '0;
          move_d   = 1'b0;
          shrink_d = 1'b0;
          if (cmd_i == ffa_pkg::CMD_ALLOC ||
              (cmd_i == ffa_pkg::CMD_RESIZE && !has_pointer_i)) begin
            state_d = S_A_SCAN;
          end else if (cmd_i == ffa_pkg::CMD_RELEASE ||
                       cmd_i == ffa_pkg::CMD_RESIZE) begin
            state_d = S_CHK_RD;
          end else begin
            state_d = S_FIN;
          end
          step_d  = '0;
          akind_d = K_NONE;
        end
      end

      S_CHK_RD: begin
        rd_addr = addr_q - AW'(1);
        size_d  = units;
        state_d = S_CHK;
      end

      S_CHK: begin
        if (addr_q == '0 || {1'b0, addr_q} >= arena_q || chk_sum > arena_q) begin
          st_d    = ffa_pkg::ST_RANGE;
          state_d = S_FIN;
        end else if (cmd_q == ffa_pkg::CMD_RELEASE || bytes_q == '0) begin
          rhdr_d  = addr_q - AW'(1);
          state_d = S_R_RD;
        end else if (size_q < SW'(rd_q) && old_m_size >= AW'(2)) begin
          // shrink in place: release the tail
          rhdr_d   = addr_q + size_q[AW-1:0];
          wr_en    = 1'b1;
          wr_addr  = addr_q + size_q[AW-1:0];
          wr_data  = old_m_size - AW'(1);
          shrink_d = 1'b1;
          hr_d     = 1'b1;
          res_d    = addr_q;
          state_d  = S_R_RD;
        end else begin
          move_d  = 1'b1;
          cp_d    = (SW'(rd_q) < size_q) ? rd_q : size_q[AW-1:0];
          step_d  = '0;
          akind_d = K_NONE;
          state_d = S_A_SCAN;
        end
      end

      S_A_SCAN: begin
        ctrl.op = ffa_pkg::CH_ROT;
        size_d  = asz;
        if (akind_q == K_NONE && live) begin
          if (hlen_w >= asz + SW'(1)) begin
            aidx_d   = step_q;
            astart_d = head.start;
            alen2_d  = newlen;
            ahdr_d   = shdr[AW-1:0];
            akind_d  = shdr[AW] ? K_FAIL : K_SPLIT;
          end else if (hlen_w >= asz) begin
            aidx_d  = step_q;
            alen2_d = head.len;
            ahdr_d  = head.start;
            akind_d = K_WHOLE;
          end
        end
        step_d = step_q + IW'(1);
        if (step_q == IW'(ffa_pkg::MAX_FREE - 1)) begin
          state_d = S_A_APPLY;
        end
      end

      S_A_APPLY: begin
        if (akind_q == K_SPLIT || akind_q == K_WHOLE) begin
          wr_en   = 1'b1;
          wr_addr = ahdr_q;
          hr_d    = 1'b1;
          res_d   = ahdr_q + AW'(1);
          if (akind_q == K_SPLIT) begin
            wr_data          = size_q[AW-1:0];
            ctrl.op          = ffa_pkg::CH_WRITE;
            ctrl.idx         = aidx_q;
            ctrl.wdata.start = astart_q;
            ctrl.wdata.len   = alen2_q;
          end else begin
            wr_data  = alen2_q;
            ctrl.op  = ffa_pkg::CH_REMOVE;
            ctrl.idx = aidx_q;
            count_d  = count_q - CW'(1);
          end
          if (move_q) begin
            mv_d    = 1'b1;
            rhdr_d  = addr_q - AW'(1);
            state_d = S_R_RD;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          st_d    = ffa_pkg::ST_NOFIT;
          cp_d    = '0;
          state_d = S_FIN;
        end
      end

      S_R_RD: begin
        rd_addr = rhdr_q;
        state_d = S_R_LAT;
      end

      S_R_LAT: begin
        alen_d  = rd_q;
        lf_d    = 1'b0;
        rf_d    = 1'b0;
        step_d  = '0;
        state_d = S_R_SCAN;
      end

      S_R_SCAN: begin
        ctrl.op = ffa_pkg::CH_ROT;
        if (live) begin
          if (!lf_q && lend == {1'b0, rhdr_q}) begin
            lf_d   = 1'b1;
            lidx_d = step_q;
            llen_d = head.len;
          end
          if (!rf_q && rbeg == {1'b0, head.start}) begin
            rf_d   = 1'b1;
            ridx_d = step_q;
            rlen_d = head.len;
          end
        end
        step_d = step_q + IW'(1);
        if (step_q == IW'(ffa_pkg::MAX_FREE - 1)) begin
          state_d = S_R_APPLY;
        end
      end

      S_R_APPLY: begin
        state_d = S_FIN;
        if (lf_q) begin
          ctrl.op          = ffa_pkg::CH_WRITE;
          ctrl.idx         = lidx_q;
          ctrl.wdata.start = rhdr_q - llen_q - AW'(1);
          if (rf_q) begin
            ctrl.wdata.len = llen_q + alen_q + rlen_q + AW'(2);
            state_d        = S_R_DEL;
          end else begin
            ctrl.wdata.len = llen_q + alen_q + AW'(1);
          end
        end else if (rf_q) begin
          ctrl.op          = ffa_pkg::CH_WRITE;
          ctrl.idx         = ridx_q;
          ctrl.wdata.start = rhdr_q;
          ctrl.wdata.len   = rlen_q + alen_q + AW'(1);
        end else if (count_q >= CW'(ffa_pkg::MAX_FREE)) begin
          st_d = ffa_pkg::ST_FULL;
        end else begin
          ctrl.op          = ffa_pkg::CH_INSERT;
          ctrl.wdata.start = rhdr_q;
          ctrl.wdata.len   = alen_q;
          count_d          = count_q + CW'(1);
        end
        // shrink commits the new length only when the tail went free
        if (shrink_q && !(!lf_q && !rf_q && count_q >= CW'(ffa_pkg::MAX_FREE))) begin
          wr_en   = 1'b1;
          wr_addr = addr_q - AW'(1);
          wr_data = size_q[AW-1:0];
        end
      end

      S_R_DEL: begin
        ctrl.op  = ffa_pkg::CH_REMOVE;
        ctrl.idx = ridx_q;
        count_d  = count_q - CW'(1);
        state_d  = S_FIN;
      end

      S_FIN: begin
        if (oload) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (oload) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      arena_q <= (AW + 1)'(ffa_pkg::ARENA_UNITS);
      count_q <= CW'(1);
      step_q  <= '0;
      akind_q <= K_NONE;
      lf_q    <= 1'b0;
      rf_q    <= 1'b0;
      move_q  <= 1'b0;
      shrink_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      arena_q <= arena_d;
      count_q <= count_d;
      step_q  <= step_d;
      akind_q <= akind_d;
      lf_q    <= lf_d;
      rf_q    <= rf_d;
      move_q  <= move_d;
      shrink_q <= shrink_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !cfg_we) begin
      cmd_q   <= cmd_i;
      bytes_q <= request_bytes_i;
      ptr_q   <= has_pointer_i;
      addr_q  <= address_i;
    end
    size_q   <= size_d;
    rhdr_q   <= rhdr_d;
    alen_q   <= alen_d;
    aidx_q   <= aidx_d;
    astart_q <= astart_d;
    alen2_q  <= alen2_d;
    ahdr_q   <= ahdr_d;
    lidx_q   <= lidx_d;
    ridx_q   <= ridx_d;
    llen_q   <= llen_d;
    rlen_q   <= rlen_d;
    st_q     <= st_d;
    hr_q     <= hr_d;
    mv_q     <= mv_d;
    res_q    <= res_d;
    cp_q     <= cp_d;
    if (oload) begin
      ost_q  <= st_q;
      ohr_q  <= hr_q;
      omv_q  <= mv_q;
      ores_q <= res_q;
      ocp_q  <= cp_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign has_result_o     = ohr_q;
  assign result_address_o = ores_q;
  assign moved_o          = omv_q;
  assign copy_units_o     = ocp_q;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator. A tracker class keeps
// its own free list and block lengths, predicts the outcome of every accepted
// command and compares it field by field with each accepted result. Stimulus
// runs over several arena sizes, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 150;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_result;
    logic [11:0] result_address;
    logic        moved;
    logic [11:0] copy_units;
  } outcome_t;

  // tracks free list, block lengths and live allocations; predicts outcomes
  class alloc_tracker;
    int unsigned arena;
    int unsigned fstart [ffa_pkg::MAX_FREE];
    int unsigned flen   [ffa_pkg::MAX_FREE];
    int unsigned fcount;
    int unsigned blen   [ffa_pkg::ARENA_UNITS];
    bit          written[ffa_pkg::ARENA_UNITS];
    int unsigned live[$];
    int unsigned known[$];
    outcome_t    pending_outcomes[$];
    int          mismatches;

    function new();
      mismatches = 0;
      arena = ffa_pkg::ARENA_UNITS;
      reform();
    endfunction

    function void reform();
      foreach (written[k]) begin
        written[k] = 0;
        blen[k] = 0;
      end
      fstart[0] = 0;
      flen[0] = arena - 1;
      fcount = 1;
      live.delete();
      known.delete();
    endfunction

    function void set_arena(int unsigned v);
      v = v & 32'h1FFF;
      if (v < 2) v = 2;
      if (v > ffa_pkg::ARENA_UNITS) v = ffa_pkg::ARENA_UNITS;
      arena = v;
      reform();
    endfunction

    function void drop_entry(int unsigned i);
      for (int unsigned k = i; k + 1 < fcount; k++) begin
        fstart[k] = fstart[k+1];
        flen[k] = flen[k+1];
      end
      fcount--;
    endfunction

    function void forget_live(int unsigned a);
      foreach (live[k]) begin
        if (live[k] == a) begin
          live.delete(k);
          return;
        end
      end
    endfunction

    function bit take_block(int unsigned size, output int unsigned a);
      int unsigned len, hdr;
      a = 0;
      for (int unsigned i = 0; i < fcount; i++) begin
        len = flen[i];
        if (len >= size + 1) begin
          len -= size + 1;
          hdr = fstart[i] + 1 + len;
          if (hdr >= ffa_pkg::ARENA_UNITS) return 0;
          flen[i] = len;
          blen[hdr] = size;
          written[hdr] = 1;
          a = hdr + 1;
          known.push_back(a);
          return 1;
        end else if (len >= size) begin
          hdr = fstart[i];
          if (hdr >= ffa_pkg::ARENA_UNITS) return 0;
          blen[hdr] = len;
          written[hdr] = 1;
          a = hdr + 1;
          known.push_back(a);
          drop_entry(i);
          return 1;
        end
      end
      return 0;
    endfunction

    // header offset, or -1 when outside the arena
    function int header_of(int unsigned a);
      if (a < 1 || a >= arena) return -1;
      if (a + blen[a-1] > arena) return -1;
      return a - 1;
    endfunction

    function logic [1:0] give_back(int unsigned hdr);
      int unsigned alen;
      int lft, rgt;
      alen = blen[hdr];
      lft = -1;
      rgt = -1;
      for (int unsigned i = 0; i < fcount; i++) begin
        if (lft < 0 && fstart[i] + 1 + flen[i] == hdr) lft = i;
        if (rgt < 0 && hdr + 1 + alen == fstart[i]) rgt = i;
        if (lft >= 0 && rgt >= 0) break;
      end
      if (lft >= 0 && rgt >= 0) begin
        flen[lft] += 2 + alen + flen[rgt];
        drop_entry(rgt);
      end else if (lft >= 0) begin
        flen[lft] += 1 + alen;
      end else if (rgt >= 0) begin
        fstart[rgt] = hdr;
        flen[rgt] += 1 + alen;
      end else begin
        if (fcount >= ffa_pkg::MAX_FREE) return ffa_pkg::ST_FULL;
        for (int k = fcount; k > 0; k--) begin
          fstart[k] = fstart[k-1];
          flen[k] = flen[k-1];
        end
        fstart[0] = hdr;
        flen[0] = alen;
        fcount++;
      end
      return ffa_pkg::ST_DONE;
    endfunction

    // predict one accepted command and queue the expected outcome
    function void note(logic [1:0] c, logic [23:0] b, logic h, logic [11:0] a);
      outcome_t o;
      int unsigned size, na, old, tail;
      int hd;
      o = '0;
      size = (int'(b) + ffa_pkg::UNIT_BYTES - 1) / ffa_pkg::UNIT_BYTES;
      if (c == ffa_pkg::CMD_ALLOC || (c == ffa_pkg::CMD_RESIZE && !h)) begin
        if (size == 0) size = 1;
        if (take_block(size, na)) begin
          o.has_result = 1;
          o.result_address = 12'(na);
          live.push_back(na);
        end else begin
          o.status = ffa_pkg::ST_NOFIT;
        end
      end else if (c == ffa_pkg::CMD_RELEASE || (c == ffa_pkg::CMD_RESIZE && b == 0)) begin
        hd = header_of(a);
        if (hd < 0) o.status = ffa_pkg::ST_RANGE;
        else begin
          o.status = give_back(hd);
          if (o.status == ffa_pkg::ST_DONE) forget_live(a);
        end
      end else if (c == ffa_pkg::CMD_RESIZE) begin
        hd = header_of(a);
        if (hd < 0) o.status = ffa_pkg::ST_RANGE;
        else begin
          old = blen[hd];
          if (size < old && old - size >= 2) begin
            // shrink in place, the tail goes back to the free list
            tail = hd + 1 + size;
            blen[tail] = old - size - 1;
            written[tail] = 1;
            known.push_back(tail + 1);
            o.status = give_back(tail);
            if (o.status == ffa_pkg::ST_DONE) blen[hd] = size;
            o.has_result = 1;
            o.result_address = a;
          end else if (take_block(size, na)) begin
            o.has_result = 1;
            o.result_address = 12'(na);
            o.moved = 1;
            o.copy_units = 12'(old < size ? old : size);
            live.push_back(na);
            o.status = give_back(hd);
            if (o.status == ffa_pkg::ST_DONE) forget_live(a);
          end else begin
            o.status = ffa_pkg::ST_NOFIT;
          end
        end
      end
      pending_outcomes.push_back(o);
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check(outcome_t got);
      outcome_t e;
      if (pending_outcomes.size() == 0) begin
        report("result with no outstanding transaction");
        return;
      end
      e = pending_outcomes.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.has_result !== e.has_result)
        report($sformatf("has_result %0d, want %0d", got.has_result, e.has_result));
      if (got.result_address !== e.result_address)
        report($sformatf("result_address %0d, want %0d",
                         got.result_address, e.result_address));
      if (got.moved !== e.moved)
        report($sformatf("moved %0d, want %0d", got.moved, e.moved));
      if (got.copy_units !== e.copy_units)
        report($sformatf("copy_units %0d, want %0d", got.copy_units, e.copy_units));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  cmd = '0;
  logic [23:0] req_bytes = '0;
  logic        has_ptr = 0;
  logic [11:0] addr = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic        has_result;
  logic [11:0] result_address;
  logic        moved;
  logic [11:0] copy_units;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_tracker tracker = new();
  int  cycles = 0;
  bit  hold_req = 0;

  first_fit_block_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .request_bytes_i(req_bytes), .has_pointer_i(has_ptr), .address_i(addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .has_result_o(has_result), .result_address_o(result_address),
    .moved_o(moved), .copy_units_o(copy_units),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // result channel monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      tracker.check({status, has_result, result_address, moved, copy_units});
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else begin
        g = gap_len();
        out_stall <= (g != 0);
        repeat (g) @(posedge clk_i);
        if (g != 0) out_stall <= 0;
        repeat ($urandom_range(40, 1)) @(posedge clk_i);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_block_allocator verification failed");
      $finish;
    end
  end

  task automatic issue(logic [1:0] c, logic [23:0] b, logic h, logic [11:0] a);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid  <= 1;
    cmd       <= c;
    req_bytes <= b;
    has_ptr   <= h;
    addr      <= a;
    do @(posedge clk_i); while (in_stall);
    tracker.note(c, b, h, a);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_arena(logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    tracker.set_arena(v);
  endtask

  function automatic logic [11:0] any_live();
    if (tracker.live.size() == 0) return 12'd0;
    return 12'(tracker.live[$urandom_range(tracker.live.size() - 1)]);
  endfunction

  function automatic logic [23:0] some_bytes();
    int unsigned top;
    if ($urandom_range(9) == 0) return 24'($urandom);
    top = (tracker.arena / 8 + 1) * ffa_pkg::UNIT_BYTES;
    return 24'($urandom_range(top));
  endfunction

  task automatic random_item();
    int r;
    logic [11:0] a;
    r = $urandom_range(99);
    if (tracker.live.size() == 0 && r >= 45 && r < 85) r = 0;
    if (r < 45) issue(ffa_pkg::CMD_ALLOC, some_bytes(), 1'($urandom_range(1)), 12'd0);
    else if (r < 65) issue(ffa_pkg::CMD_RELEASE, 24'($urandom), 1'($urandom_range(1)),
                           any_live());
    else if (r < 85) issue(ffa_pkg::CMD_RESIZE,
                           ($urandom_range(7) == 0) ? 24'd0 : some_bytes(), 1'b1,
                           any_live());
    else if (r < 90) issue(ffa_pkg::CMD_RESIZE, some_bytes(), 1'b0, 12'($urandom));
    else if (r < 95) begin
      // stale or out-of-range address
      if (tracker.known.size() != 0 && $urandom_range(1))
        a = 12'(tracker.known[$urandom_range(tracker.known.size() - 1)]);
      else if (tracker.arena < ffa_pkg::ARENA_UNITS && $urandom_range(1))
        a = 12'($urandom_range(ffa_pkg::ARENA_UNITS - 1, tracker.arena));
      else
        a = 12'd0;
      issue($urandom_range(1) ? ffa_pkg::CMD_RELEASE : ffa_pkg::CMD_RESIZE, some_bytes(),
            1'b1, a);
    end else issue(2'd3, 24'($urandom), 1'($urandom_range(1)), 12'($urandom));
  endtask

  initial begin
    int unsigned victims[$];
    logic [11:0] a;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: sizes, every command, special cases
    issue(ffa_pkg::CMD_ALLOC, 24'd0, 0, 0);
    issue(ffa_pkg::CMD_ALLOC, 24'd1, 1, 12'hFFF);
    issue(ffa_pkg::CMD_ALLOC, 24'd16, 0, 0);
    issue(ffa_pkg::CMD_ALLOC, 24'd17, 0, 0);
    issue(ffa_pkg::CMD_ALLOC, 24'd800, 0, 0);
    issue(ffa_pkg::CMD_ALLOC, 24'hFFFFFF, 0, 0);                     // no fit
    issue(2'd3, 24'hFFFFFF, 1, 12'hFFF);                             // unused command
    a = 12'(tracker.live[0]);
    issue(ffa_pkg::CMD_RELEASE, 24'd0, 0, a);
    issue(ffa_pkg::CMD_RELEASE, 24'd0, 0, a);                        // release twice
    issue(ffa_pkg::CMD_RELEASE, 24'd0, 0, 12'd0);                    // outside arena
    issue(ffa_pkg::CMD_RESIZE, 24'd40, 0, 0);                        // no pointer
    issue(ffa_pkg::CMD_RESIZE, 24'd0, 1, 12'(tracker.live[$]));      // resize to zero
    issue(ffa_pkg::CMD_RESIZE, 24'd160, 1, 12'(tracker.live[$]));    // shrink in place
    issue(ffa_pkg::CMD_RESIZE, 24'd800, 1, 12'(tracker.live[$]));    // grow, moves
    issue(ffa_pkg::CMD_RESIZE, 24'd16, 1, 12'(tracker.live[0]));     // same size, moves
    issue(ffa_pkg::CMD_RESIZE, 24'hFFFFFF, 1, 12'(tracker.live[0])); // no fit on resize
    for (int k = 0; k < 150; k++) random_item();

    // fragment the list until the free table is full
    wait_idle();
    write_arena(32'd4096);
    for (int k = 0; k < 140; k++) issue(ffa_pkg::CMD_ALLOC, 24'd16, 0, 0);
    victims = tracker.live;
    for (int k = 0; k < victims.size(); k += 2)
      issue(ffa_pkg::CMD_RELEASE, 24'd0, 0, 12'(victims[k]));
    for (int k = 0; k < 20; k++)
      issue(ffa_pkg::CMD_RESIZE, 24'd1, 1, 12'(victims[2 * $urandom_range(60) + 1]));
    hold_req = 1;
    for (int k = 0; k < 100; k++) random_item();

    // random phases over several arena sizes, extremes included
    begin
      logic [31:0] sizes[7];
      sizes = '{32'd2, 32'd8191, 32'd37, 32'd0, 32'd300, 32'h2005, 32'd4096};
      foreach (sizes[p]) begin
        wait_idle();
        write_arena(sizes[p]);
        for (int k = 0; k < 140; k++) random_item();
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0)
      $display("first_fit_block_allocator verification clean");
    else
      $display("first_fit_block_allocator verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ffa_pkg.sv
rtl/core/ffa_cell.sv
rtl/core/ffa_chain.sv
rtl/core/first_fit_block_allocator.sv
test/tb.sv
